@@ design/integer_to_radix_ascii_macros.svh @@
// Assertion macros used by the checker file.
`ifndef INTEGER_TO_RADIX_ASCII_MACROS_SVH
`define INTEGER_TO_RADIX_ASCII_MACROS_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define ITRA_ASSERT_NOW(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define ITRA_ASSERT_NEXT(label, cond, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (cons)) \
        else $error(msg);

`endif

@@ design/itra_pkg.sv @@
package itra_pkg;

    localparam int WORD_BITS  = 32;
    localparam int MAX_CHARS  = WORD_BITS + 1;
    localparam int CNT_BITS   = $clog2(MAX_CHARS + 1);
    localparam int ADDR_BITS  = $clog2(MAX_CHARS);
    localparam int RADIX_BITS = 6;
    localparam int CHAR_BITS  = 7;

    localparam int DIV_STEP     = 4;
    localparam int DIV_CYCLES   = WORD_BITS / DIV_STEP;
    localparam int DIV_CNT_BITS = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

    localparam logic [RADIX_BITS-1:0] RADIX_RESET  = RADIX_BITS'(10);
    localparam logic [RADIX_BITS-1:0] RADIX_MIN    = RADIX_BITS'(2);
    localparam logic [RADIX_BITS-1:0] RADIX_MAX    = RADIX_BITS'(36);
    localparam logic [RADIX_BITS-1:0] RADIX_SIGNED = RADIX_BITS'(10);
    localparam logic [RADIX_BITS-1:0] DIGIT_TEN    = RADIX_BITS'(10);

    localparam logic [CHAR_BITS-1:0] CHAR_ZERO   = CHAR_BITS'(8'h30);
    localparam logic [CHAR_BITS-1:0] CHAR_LETTER = CHAR_BITS'(8'h41);
    localparam logic [CHAR_BITS-1:0] CHAR_MINUS  = CHAR_BITS'(8'h2D);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LAUNCH,
        ST_DIVIDE,
        ST_SIGN,
        ST_FETCH,
        ST_SHOW
    } state_t;

    typedef struct packed {
        logic                  start;
        logic [WORD_BITS-1:0]  dividend;
        logic [RADIX_BITS-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                  done;
        logic [WORD_BITS-1:0]  quotient;
        logic [RADIX_BITS-1:0] remainder;
    } div_rsp_t;

    function automatic logic [CHAR_BITS-1:0] digit_char(input logic [RADIX_BITS-1:0] d);
        logic [CHAR_BITS-1:0] c;
        if (d < DIGIT_TEN) begin
            c = CHAR_ZERO + CHAR_BITS'(d);
        end else begin
            c = CHAR_LETTER + CHAR_BITS'(d - DIGIT_TEN);
        end
        return c;
    endfunction

endpackage

@@ design/itra_div.sv @@
module itra_div (
    input  logic               aclk,
    input  logic               aresetn,
    input  itra_pkg::div_req_t req,
    output itra_pkg::div_rsp_t rsp
);

    logic                                busy_reg, busy_next;
    logic                                done_reg, done_next;
    logic [itra_pkg::DIV_CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [itra_pkg::WORD_BITS-1:0]      q_reg, q_next;
    logic [itra_pkg::RADIX_BITS-1:0]     rem_reg, rem_next;
    logic [itra_pkg::RADIX_BITS-1:0]     div_reg, div_next;
    logic [itra_pkg::WORD_BITS-1:0]      q_step;
    logic [itra_pkg::RADIX_BITS-1:0]     rem_step;

    // restoring division, several quotient bits per cycle
    always_comb begin
        logic [itra_pkg::RADIX_BITS:0] part;
        q_step   = q_reg;
        rem_step = rem_reg;
        for (int i = 0; i < itra_pkg::DIV_STEP; i++) begin
            part   = {rem_step, q_step[itra_pkg::WORD_BITS-1]};
            q_step = {q_step[itra_pkg::WORD_BITS-2:0], 1'b0};
            if (part >= {1'b0, div_reg}) begin
                part      = part - {1'b0, div_reg};
                q_step[0] = 1'b1;
            end
            rem_step = part[itra_pkg::RADIX_BITS-1:0];
        end
    end

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        if (busy_reg) begin
            q_next   = q_step;
            rem_next = rem_step;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == itra_pkg::DIV_CNT_BITS'(itra_pkg::DIV_CYCLES - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end else if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            q_next    = req.dividend;
            rem_next  = '0;
            div_next  = req.divisor;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        q_reg   <= q_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign rsp.done      = done_reg;
    assign rsp.quotient  = q_reg;
    assign rsp.remainder = rem_reg;

endmodule

@@ design/integer_to_radix_ascii.sv @@
// Converts one 32-bit two's complement word on the s_ stream into its ASCII text on the
// m_ stream, most significant digit first, with m_tlast on the final character. The radix
// comes from the configuration channel (reset 10, values below 2 or above 36 act as 2 or
// 36); only radix ten shows a leading '-' for negative words, every other radix reads the
// word as unsigned. The block takes one word at a time: s_tready is high only while idle.
// Each digit takes a launch step, a run of the shared divider at 4 quotient bits a cycle and a
// capture step that writes the digit into the digit buffer; a negative decimal word then
// writes its sign, and each character is then read back from the digit buffer and presented,
// holding while m_tready is low.
module integer_to_radix_ascii (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] character, [7] zero
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [5:0]  cfg_data
);

    itra_pkg::state_t                 state_reg, state_next;
    logic [itra_pkg::RADIX_BITS-1:0]  radix_reg;
    logic [itra_pkg::RADIX_BITS-1:0]  radix_eff;
    logic [itra_pkg::RADIX_BITS-1:0]  radix_eff_reg, radix_eff_next;
    logic                             neg_reg, neg_next;
    logic [itra_pkg::WORD_BITS-1:0]   quotient_reg, quotient_next;
    logic [itra_pkg::CNT_BITS-1:0]    count_reg, count_next;
    logic [itra_pkg::ADDR_BITS-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [itra_pkg::CHAR_BITS-1:0]   char_reg;
    logic                             last_reg;
    logic [itra_pkg::CHAR_BITS-1:0]   buffer_mem [itra_pkg::MAX_CHARS];

    logic                             wr_en;
    logic [itra_pkg::CHAR_BITS-1:0]   wr_data;
    logic                             rd_en;
    logic                             div_start;
    logic                             s_accept;
    logic                             m_accept;

    itra_pkg::div_req_t               div_req;
    itra_pkg::div_rsp_t               div_rsp;

    assign s_accept  = s_tvalid && s_tready;
    assign m_accept  = m_tvalid && m_tready;
    assign cfg_ready = 1'b1;

    always_comb begin
        if (radix_reg < itra_pkg::RADIX_MIN) begin
            radix_eff = itra_pkg::RADIX_MIN;
        end else if (radix_reg > itra_pkg::RADIX_MAX) begin
            radix_eff = itra_pkg::RADIX_MAX;
        end else begin
            radix_eff = radix_reg;
        end
    end

    assign div_req.start    = div_start;
    assign div_req.dividend = quotient_reg;
    assign div_req.divisor  = radix_eff_reg;

    itra_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            itra_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = itra_pkg::ST_LAUNCH;
                end
            end
            itra_pkg::ST_LAUNCH: begin
                state_next = itra_pkg::ST_DIVIDE;
            end
            itra_pkg::ST_DIVIDE: begin
                if (div_rsp.done) begin
                    if (div_rsp.quotient != '0) begin
                        state_next = itra_pkg::ST_LAUNCH;
                    end else if (neg_reg) begin
                        state_next = itra_pkg::ST_SIGN;
                    end else begin
                        state_next = itra_pkg::ST_FETCH;
                    end
                end
            end
            itra_pkg::ST_SIGN: begin
                state_next = itra_pkg::ST_FETCH;
            end
            itra_pkg::ST_FETCH: begin
                state_next = itra_pkg::ST_SHOW;
            end
            itra_pkg::ST_SHOW: begin
                if (m_tready) begin
                    state_next = last_reg ? itra_pkg::ST_IDLE : itra_pkg::ST_FETCH;
                end
            end
            default: begin
                state_next = itra_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        m_tvalid  = 1'b0;
        div_start = 1'b0;
        wr_en     = 1'b0;
        rd_en     = 1'b0;
        wr_data   = itra_pkg::digit_char(div_rsp.remainder);
        unique case (state_reg)
            itra_pkg::ST_IDLE:   s_tready  = 1'b1;
            itra_pkg::ST_LAUNCH: div_start = 1'b1;
            itra_pkg::ST_DIVIDE: wr_en     = div_rsp.done;
            itra_pkg::ST_SIGN: begin
                wr_en   = 1'b1;
                wr_data = itra_pkg::CHAR_MINUS;
            end
            itra_pkg::ST_FETCH:  rd_en     = 1'b1;
            itra_pkg::ST_SHOW:   m_tvalid  = 1'b1;
            default: begin
                s_tready = 1'b0;
            end
        endcase
    end

    always_comb begin
        radix_eff_next = radix_eff_reg;
        neg_next       = neg_reg;
        quotient_next  = quotient_reg;
        count_next     = count_reg;
        rd_ptr_next    = rd_ptr_reg;
        priority if (s_accept) begin
            radix_eff_next = radix_eff;
            neg_next       = (radix_eff == itra_pkg::RADIX_SIGNED) &&
                             s_tdata[itra_pkg::WORD_BITS-1];
            quotient_next  = neg_next ? (itra_pkg::WORD_BITS'(0) - s_tdata) : s_tdata;
            count_next     = '0;
        end else if (wr_en) begin
            if (state_reg == itra_pkg::ST_DIVIDE) begin
                quotient_next = div_rsp.quotient;
            end
            count_next  = count_reg + 1'b1;
            rd_ptr_next = count_reg[itra_pkg::ADDR_BITS-1:0];
        end else if (m_accept && !last_reg) begin
            rd_ptr_next = rd_ptr_reg - 1'b1;
        end else begin
            rd_ptr_next = rd_ptr_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= itra_pkg::ST_IDLE;
            radix_reg    <= itra_pkg::RADIX_RESET;
            neg_reg      <= 1'b0;
            quotient_reg <= '0;
            count_reg    <= '0;
            rd_ptr_reg   <= '0;
        end else begin
            state_reg    <= state_next;
            neg_reg      <= neg_next;
            quotient_reg <= quotient_next;
            count_reg    <= count_next;
            rd_ptr_reg   <= rd_ptr_next;
            if (cfg_valid && cfg_ready) begin
                radix_reg <= cfg_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        radix_eff_reg <= radix_eff_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            buffer_mem[count_reg[itra_pkg::ADDR_BITS-1:0]] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            char_reg <= buffer_mem[rd_ptr_reg];
            last_reg <= (rd_ptr_reg == '0);
        end
    end

    assign m_tdata = {1'b0, char_reg};
    assign m_tlast = last_reg;

endmodule

@@ design/itra_checker.sv @@
`include "integer_to_radix_ascii_macros.svh"

module itra_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    `ITRA_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled output word changed")
    `ITRA_ASSERT_NOW(a_one_side, m_tvalid, !s_tready, "input ready while an output word is shown")
    `ITRA_ASSERT_NEXT(a_busy_after_in, s_tvalid && s_tready, !s_tready && !m_tvalid, "block not busy after an input word")
    `ITRA_ASSERT_NEXT(a_idle_after_last, m_tvalid && m_tready && m_tlast, s_tready && !m_tvalid, "block not idle after the last character")

endmodule

bind integer_to_radix_ascii itra_checker u_itra_checker (.*);

@@ verif/tb_integer_to_radix_ascii.sv @@
`timescale 1ns / 1ps

module tb_integer_to_radix_ascii;

    import itra_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int TAIL_CYCLES    = 60;
    localparam int PHASE_WORDS    = 33;

    typedef struct packed {
        logic [CHAR_BITS-1:0] code;
        logic                 is_last;
    } ascii_char_t;

    logic                  aclk = 1'b1;
    logic                  aresetn = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [WORD_BITS-1:0]  s_tdata = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [7:0]            m_tdata;
    logic                  m_tlast;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [RADIX_BITS-1:0] cfg_data = '0;

    logic [WORD_BITS-1:0]  words_pending[$];
    ascii_char_t           text_due[$];
    ascii_char_t           due;
    logic [RADIX_BITS-1:0] radix_now = RADIX_RESET;

    int  errors = 0;
    int  words_in = 0;
    int  chars_seen = 0;
    int  radix_writes = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  recv_pick;
    int  hold_left = 0;
    int  hold_asked = 0;
    int  hold_given = 0;
    int  quiet = 0;
    bit  steady = 1'b0;

    integer_to_radix_ascii i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always begin
        #5 aclk = 1'b0;
        #5 aclk = 1'b1;
    end

    function automatic int eff_radix(input logic [RADIX_BITS-1:0] reg_radix);
        if (reg_radix < RADIX_MIN) begin
            return RADIX_MIN;
        end else if (reg_radix > RADIX_MAX) begin
            return RADIX_MAX;
        end
        return reg_radix;
    endfunction

    function automatic void predict_text(input logic [WORD_BITS-1:0] word,
                                         input logic [RADIX_BITS-1:0] reg_radix);
        logic [WORD_BITS-1:0] quot;
        logic [WORD_BITS-1:0] base;
        logic [RADIX_BITS-1:0] digit;
        logic                  negative;
        logic [CHAR_BITS-1:0]  text[$];
        ascii_char_t           ch;
        base = WORD_BITS'(eff_radix(reg_radix));
        negative = (base == WORD_BITS'(RADIX_SIGNED)) && word[WORD_BITS-1];
        quot = negative ? -word : word;
        do begin
            digit = RADIX_BITS'(quot % base);
            if (digit < 10) begin
                text.push_front(CHAR_ZERO + CHAR_BITS'(digit));
            end else begin
                text.push_front(CHAR_LETTER + CHAR_BITS'(digit - 10));
            end
            quot = quot / base;
        end while (quot != 0);
        if (negative) begin
            text.push_front(CHAR_MINUS);
        end
        foreach (text[i]) begin
            ch.code    = text[i];
            ch.is_last = (i == text.size() - 1);
            text_due.push_back(ch);
        end
    endfunction

    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(1, 3);
        end else if (roll < 97) begin
            return $urandom_range(4, 15);
        end
        return $urandom_range(30, 120);
    endfunction

    function automatic logic [WORD_BITS-1:0] rand_word(input logic [RADIX_BITS-1:0] reg_radix);
        logic [63:0] pw;
        int          base;
        base = eff_radix(reg_radix);
        pw = 64'd1;
        case ($urandom_range(0, 6))
            0: return WORD_BITS'($urandom_range(0, 40));
            1: return -WORD_BITS'($urandom_range(1, 40));
            2: return WORD_BITS'($urandom >> $urandom_range(0, 31));
            3: begin
                repeat ($urandom_range(1, 31)) begin
                    if (pw * base <= 64'hFFFF_FFFF) begin
                        pw = pw * base;
                    end
                end
                return WORD_BITS'(pw + 64'($urandom_range(0, 2)) - 64'd1);
            end
            4: begin
                if ($urandom_range(0, 1)) begin
                    return {1'b1, {(WORD_BITS-1){1'b0}}} | WORD_BITS'($urandom_range(0, 3));
                end
                return ~WORD_BITS'($urandom_range(0, 3));
            end
            default: return WORD_BITS'($urandom);
        endcase
    endfunction

    task automatic flag_mismatch(input string msg);
        errors++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    task automatic write_radix(input logic [RADIX_BITS-1:0] value);
        @(posedge aclk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) begin
            @(posedge aclk);
        end
        cfg_valid <= 1'b0;
        radix_now = value;
        radix_writes++;
    endtask

    task automatic wait_drained();
        @(posedge aclk);
        while (words_pending.size() != 0 || s_tvalid || text_due.size() != 0) begin
            @(posedge aclk);
        end
    endtask

    task automatic run_random(input logic [RADIX_BITS-1:0] value, input int count);
        write_radix(value);
        repeat (count) begin
            words_pending.push_back(rand_word(value));
        end
        wait_drained();
    endtask

    // sender
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            send_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                predict_text(s_tdata, radix_now);
                words_in++;
            end
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                s_tvalid <= 1'b0;
            end else if (words_pending.size() != 0) begin
                s_tdata  <= words_pending.pop_front();
                s_tvalid <= 1'b1;
                send_gap <= steady ? 0 : pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // receiver and checker
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (text_due.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word 0x%02h last %0b", m_tdata, m_tlast));
                end else begin
                    due = text_due.pop_front();
                    chars_seen++;
                    if (m_tdata !== {1'b0, due.code}) begin
                        flag_mismatch($sformatf("character 0x%02h, want 0x%02h", m_tdata, due.code));
                    end
                    if (m_tlast !== due.is_last) begin
                        flag_mismatch($sformatf("last %0b, want %0b on character 0x%02h",
                                                m_tlast, due.is_last, due.code));
                    end
                end
            end
            if (hold_left > 0) begin
                hold_left <= hold_left - 1;
                m_tready  <= 1'b0;
            end else if (hold_given != hold_asked) begin
                hold_given <= hold_given + 1;
                hold_left  <= HOLD_CYCLES;
                m_tready   <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap <= recv_gap - 1;
                m_tready <= 1'b0;
            end else begin
                recv_pick = steady ? 0 : pick_gap();
                m_tready <= (recv_pick == 0);
                recv_gap <= (recv_pick > 0) ? recv_pick - 1 : 0;
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)
                || (cfg_valid && cfg_ready)) begin
            quiet <= 0;
        end else if (quiet >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles, %0d characters outstanding",
                     quiet, text_due.size());
            $display("tb: failure");
            $finish;
        end else begin
            quiet <= quiet + 1;
        end
    end

    initial begin
        logic [RADIX_BITS-1:0] sweep[$];
        logic [RADIX_BITS-1:0] pick;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        write_radix(RADIX_SIGNED);
        words_pending = '{32'd0, 32'hFFFF_FFFF, 32'd1, 32'h8000_0000, 32'h7FFF_FFFF,
                          32'd9, 32'd10, -32'd9, 32'd1_000_000_000, 32'h8000_0001};
        wait_drained();
        write_radix(RADIX_MIN);
        words_pending = '{32'd0, 32'hFFFF_FFFF, 32'h8000_0000, 32'd1};
        wait_drained();
        write_radix(RADIX_MAX);
        words_pending = '{32'd35, 32'd36, 32'hFFFF_FFFF, 32'd0, 32'h7FFF_FFFF};
        wait_drained();
        write_radix(6'd0);
        words_pending = '{32'd5, 32'hFFFF_FFFF};
        wait_drained();
        write_radix(6'd63);
        words_pending = '{32'hDEAD_BEEF};
        wait_drained();
        write_radix(6'd37);
        words_pending = '{32'd36, 32'h8000_0000};
        wait_drained();

        // fill the block while the receiver holds off
        write_radix(6'd16);
        repeat (PHASE_WORDS) begin
            words_pending.push_back(rand_word(6'd16));
        end
        hold_asked++;
        wait_drained();

        sweep = '{RADIX_SIGNED, RADIX_MIN, RADIX_MAX, 6'd1, 6'd63, 6'd37, 6'd8, 6'd3};
        foreach (sweep[i]) begin
            steady = (i % 4 == 2);
            run_random(sweep[i], PHASE_WORDS);
        end
        repeat (4) begin
            steady = 1'b0;
            pick = $urandom_range(0, 1) ? RADIX_BITS'($urandom_range(0, 63))
                                        : RADIX_BITS'($urandom_range(2, 36));
            run_random(pick, PHASE_WORDS);
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        $display("run: %0d words converted, %0d characters checked", words_in, chars_seen);
        $display("run: %0d radix writes, out-of-range bases and long output hold included",
                 radix_writes);
        if (errors == 0 && text_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("%0d mismatches, %0d characters never seen", errors, text_due.size());
            $display("tb: failure");
        end
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+design
design/itra_pkg.sv
design/itra_div.sv
design/integer_to_radix_ascii.sv
design/itra_checker.sv
verif/tb_integer_to_radix_ascii.sv
